[hw/rtl/tachometer_speed_step_controller_macros.svh]
// assertion macros for the tachometer speed step controller checker
// expects signals named clock and reset in the scope that uses them
`ifndef TACHOMETER_SPEED_STEP_CONTROLLER_MACROS_SVH
`define TACHOMETER_SPEED_STEP_CONTROLLER_MACROS_SVH

// same-cycle implication, off during reset
`define TSSC_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off during reset
`define TSSC_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication, also checked around reset
`define TSSC_ASSERT_ALL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/tssc_pkg.sv]
// shared types and constants of the tachometer speed step controller
// no dependencies
package tssc_pkg;

   localparam int SAMPLES_DEFAULT = 4;

   localparam int PERIOD_W = 16;
   localparam int DUTY_W   = 14;
   localparam int RPM_W    = 16;
   localparam int TARGET_W = 10;
   localparam int DIV_W    = 21;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 10;

   localparam logic [DIV_W-1:0]    RPM_NUMERATOR = 21'd2000000;
   localparam logic [RPM_W-1:0]    RPM_MAX       = 16'hFFFF;
   localparam int                  DEAD_BAND     = 3;
   localparam logic [DUTY_W-1:0]   DUTY_STEP     = 14'd100;
   localparam logic [DUTY_W-1:0]   DUTY_LOW      = 14'd100;
   localparam logic [DUTY_W-1:0]   DUTY_HIGH     = 14'd14898;
   localparam logic [DUTY_W-1:0]   DUTY_RESET    = 14'd3750;
   localparam logic [TARGET_W-1:0] TARGET_RESET  = 10'd70;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TARGET_LEFT  = 2'd0,
      CSR_TARGET_RIGHT = 2'd1,
      CSR_DRIVE_EN     = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [PERIOD_W-1:0] left_period;
      logic [PERIOD_W-1:0] right_period;
   } req_type;

   typedef struct packed {
      logic [DUTY_W-1:0] duty_left;
      logic [DUTY_W-1:0] duty_right;
      logic [RPM_W-1:0]  rpm_left;
      logic [RPM_W-1:0]  rpm_right;
      logic              updated;
      logic              motor_on;
   } rsp_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [DIV_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;

endpackage

[hw/rtl/tachometer_speed_step_controller.sv]
// top level of the tachometer speed step controller: control registers,
// output register, sequencer and shared divider; depends on tssc_pkg
//
//   port group   direction   flow control     payload
//   req_         in          valid / stall    tssc_pkg::req_type
//   rsp_         out         valid / stall    tssc_pkg::rsp_type
//   csr_         in          write enable     index and 10-bit data
//
// an item that does not complete the sample buffers passes from idle through the
// done state; the item that completes them runs the divider up to four times
// (mean and rpm per wheel, rpm skipped on a zero mean) plus sequencing
// the output register lets the next transfer in while a result waits
// synchronous reset, no clearing pass
module tachometer_speed_step_controller #(
   parameter int SAMPLES_PER_UPDATE = tssc_pkg::SAMPLES_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  tssc_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output tssc_pkg::rsp_type               rsp_data,
   input  logic                            csr_write_en,
   input  logic [tssc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tssc_pkg::CSR_DATA_W-1:0] csr_data
);
   import tssc_pkg::*;

   logic [TARGET_W-1:0] target_left_ff, target_left_in;
   logic [TARGET_W-1:0] target_right_ff, target_right_in;
   logic                drive_en_ff, drive_en_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   logic        in_ready;
   logic        res_valid;
   logic        res_free;
   rsp_type     res_data;
   div_req_type div_req;
   div_rsp_type div_rsp;

   always_comb begin
      target_left_in  = target_left_ff;
      target_right_in = target_right_ff;
      drive_en_in     = drive_en_ff;
      if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_TARGET_LEFT:  target_left_in  = csr_data[TARGET_W-1:0];
            CSR_TARGET_RIGHT: target_right_in = csr_data[TARGET_W-1:0];
            CSR_DRIVE_EN:     drive_en_in     = csr_data[0];
            default: ;
         endcase
      end
   end

   assign res_free = ~rsp_valid_ff | ~rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_valid && res_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_data;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_left_ff  <= TARGET_RESET;
         target_right_ff <= TARGET_RESET;
         drive_en_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         target_left_ff  <= target_left_in;
         target_right_ff <= target_right_in;
         drive_en_ff     <= drive_en_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   tssc_seq #(
      .SAMPLES_PER_UPDATE (SAMPLES_PER_UPDATE)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_valid),
      .in_ready     (in_ready),
      .in_data      (req_data),
      .target_left  (target_left_ff),
      .target_right (target_right_ff),
      .drive_en     (drive_en_ff),
      .res_valid    (res_valid),
      .res_free     (res_free),
      .res_data     (res_data),
      .div_req      (div_req),
      .div_rsp      (div_rsp)
   );

   tssc_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign req_stall = ~in_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[hw/rtl/tssc_div.sv]
// shared restoring divider, one quotient bit per cycle
// depends on tssc_pkg
module tssc_div (
   input  logic                 clock,
   input  logic                 reset,
   input  tssc_pkg::div_req_type req,
   output tssc_pkg::div_rsp_type rsp
);
   import tssc_pkg::*;

   localparam int CNT_W = $clog2(DIV_W + 1);

   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [DIV_W-1:0] dsr_ff, dsr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             done_ff, done_in;
   logic [DIV_W:0]   trial;
   logic             fits;

   always_comb begin
      trial   = {rem_ff, quo_ff[DIV_W-1]};
      fits    = trial >= {1'b0, dsr_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (req.start) begin
         rem_in = '0;
         quo_in = req.dividend;
         dsr_in = req.divisor;
         cnt_in = CNT_W'(DIV_W);
      end else if (cnt_ff != '0) begin
         rem_in  = fits ? DIV_W'(trial - {1'b0, dsr_ff}) : trial[DIV_W-1:0];
         quo_in  = {quo_ff[DIV_W-2:0], fits};
         cnt_in  = cnt_ff - CNT_W'(1);
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

[hw/rtl/tssc_seq.sv]
// sequencer: sample sums, mean and rpm through the shared divider, duty steps
// depends on tssc_pkg, drives tssc_div
module tssc_seq #(
   parameter int SAMPLES_PER_UPDATE = tssc_pkg::SAMPLES_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  tssc_pkg::req_type              in_data,
   input  logic [tssc_pkg::TARGET_W-1:0]  target_left,
   input  logic [tssc_pkg::TARGET_W-1:0]  target_right,
   input  logic                           drive_en,
   output logic                           res_valid,
   input  logic                           res_free,
   output tssc_pkg::rsp_type              res_data,
   output tssc_pkg::div_req_type          div_req,
   input  tssc_pkg::div_rsp_type          div_rsp
);
   import tssc_pkg::*;

   localparam int IDX_W = (SAMPLES_PER_UPDATE > 1) ? $clog2(SAMPLES_PER_UPDATE) : 1;
   localparam int SUM_W = PERIOD_W + IDX_W;
   localparam logic [IDX_W-1:0] IDX_LAST    = IDX_W'(SAMPLES_PER_UPDATE - 1);
   localparam logic [DIV_W-1:0] DIV_SAMPLES = DIV_W'(SAMPLES_PER_UPDATE);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MEAN,
      ST_MEAN_WAIT,
      ST_RPM_WAIT,
      ST_STEP,
      ST_DONE
   } state_type;

   state_type         state_ff, state_in;
   logic              wheel_ff, wheel_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [SUM_W-1:0]  sum_left_ff, sum_left_in;
   logic [SUM_W-1:0]  sum_right_ff, sum_right_in;
   logic [RPM_W-1:0]  rpm_left_ff, rpm_left_in;
   logic [RPM_W-1:0]  rpm_right_ff, rpm_right_in;
   logic [DUTY_W-1:0] duty_left_ff, duty_left_in;
   logic [DUTY_W-1:0] duty_right_ff, duty_right_in;
   logic              updated_ff, updated_in;

   logic [SUM_W-1:0]    sum_sel;
   logic [RPM_W-1:0]    rpm_sel;
   logic [RPM_W-1:0]    rpm_new;
   logic [DUTY_W-1:0]   duty_sel;
   logic [DUTY_W-1:0]   duty_new;
   logic [TARGET_W-1:0] tgt_sel;
   logic                too_fast;
   logic                too_slow;

   always_comb begin
      sum_sel  = wheel_ff ? sum_right_ff : sum_left_ff;
      rpm_sel  = wheel_ff ? rpm_right_ff : rpm_left_ff;
      duty_sel = wheel_ff ? duty_right_ff : duty_left_ff;
      tgt_sel  = wheel_ff ? target_right : target_left;

      too_fast = ((RPM_W+1)'(rpm_sel) > (RPM_W+1)'(tgt_sel) + (RPM_W+1)'(DEAD_BAND));
      too_slow = ((RPM_W+1)'(rpm_sel) + (RPM_W+1)'(DEAD_BAND) < (RPM_W+1)'(tgt_sel));
      if (too_fast && duty_sel > DUTY_LOW) begin
         duty_new = duty_sel - DUTY_STEP;
      end else if (too_slow && duty_sel < DUTY_HIGH) begin
         duty_new = duty_sel + DUTY_STEP;
      end else begin
         duty_new = duty_sel;
      end

      if (div_rsp.quotient > DIV_W'(RPM_MAX)) begin
         rpm_new = RPM_MAX;
      end else begin
         rpm_new = div_rsp.quotient[RPM_W-1:0];
      end

      state_in         = state_ff;
      wheel_in         = wheel_ff;
      idx_in           = idx_ff;
      sum_left_in      = sum_left_ff;
      sum_right_in     = sum_right_ff;
      rpm_left_in      = rpm_left_ff;
      rpm_right_in     = rpm_right_ff;
      duty_left_in     = duty_left_ff;
      duty_right_in    = duty_right_ff;
      updated_in       = updated_ff;
      div_req.start    = 1'b0;
      div_req.dividend = DIV_W'(sum_sel);
      div_req.divisor  = DIV_SAMPLES;

      unique case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               if (idx_ff == '0) begin
                  sum_left_in  = SUM_W'(in_data.left_period);
                  sum_right_in = SUM_W'(in_data.right_period);
               end else begin
                  sum_left_in  = sum_left_ff + SUM_W'(in_data.left_period);
                  sum_right_in = sum_right_ff + SUM_W'(in_data.right_period);
               end
               if (idx_ff == IDX_LAST) begin
                  idx_in   = '0;
                  wheel_in = 1'b0;
                  state_in = ST_MEAN;
               end else begin
                  idx_in     = idx_ff + IDX_W'(1);
                  updated_in = 1'b0;
                  state_in   = ST_DONE;
               end
            end
         end
         ST_MEAN: begin
            div_req.start = 1'b1;
            state_in      = ST_MEAN_WAIT;
         end
         ST_MEAN_WAIT: begin
            if (div_rsp.done) begin
               if (div_rsp.quotient == '0) begin
                  if (wheel_ff) begin
                     rpm_right_in = RPM_MAX;
                  end else begin
                     rpm_left_in = RPM_MAX;
                  end
                  state_in = ST_STEP;
               end else begin
                  div_req.start    = 1'b1;
                  div_req.dividend = RPM_NUMERATOR;
                  div_req.divisor  = div_rsp.quotient;
                  state_in         = ST_RPM_WAIT;
               end
            end
         end
         ST_RPM_WAIT: begin
            if (div_rsp.done) begin
               if (wheel_ff) begin
                  rpm_right_in = rpm_new;
               end else begin
                  rpm_left_in = rpm_new;
               end
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            if (wheel_ff) begin
               duty_right_in = duty_new;
               updated_in    = 1'b1;
               state_in      = ST_DONE;
            end else begin
               duty_left_in = duty_new;
               wheel_in     = 1'b1;
               state_in     = ST_MEAN;
            end
         end
         ST_DONE: begin
            if (res_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         wheel_ff      <= 1'b0;
         idx_ff        <= '0;
         rpm_left_ff   <= '0;
         rpm_right_ff  <= '0;
         duty_left_ff  <= DUTY_RESET;
         duty_right_ff <= DUTY_RESET;
         updated_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         wheel_ff      <= wheel_in;
         idx_ff        <= idx_in;
         rpm_left_ff   <= rpm_left_in;
         rpm_right_ff  <= rpm_right_in;
         duty_left_ff  <= duty_left_in;
         duty_right_ff <= duty_right_in;
         updated_ff    <= updated_in;
      end
      sum_left_ff  <= sum_left_in;
      sum_right_ff <= sum_right_in;
   end

   assign in_ready  = (state_ff == ST_IDLE);
   assign res_valid = (state_ff == ST_DONE);

   assign res_data.duty_left  = duty_left_ff;
   assign res_data.duty_right = duty_right_ff;
   assign res_data.rpm_left   = rpm_left_ff;
   assign res_data.rpm_right  = rpm_right_ff;
   assign res_data.updated    = updated_ff;
   assign res_data.motor_on   = drive_en;

endmodule

[hw/rtl/tssc_chk.sv]
// port-level assertions for the tachometer speed step controller, with bind
// depends on tssc_pkg and tachometer_speed_step_controller_macros.svh
`include "tachometer_speed_step_controller_macros.svh"

module tssc_chk (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input tssc_pkg::rsp_type rsp_data
);
   import tssc_pkg::*;

   localparam logic [DUTY_W-1:0] DUTY_BOUND = DUTY_HIGH + DUTY_STEP;

   logic duty_ok;
   logic rsp_wait;

   assign duty_ok  = (rsp_data.duty_left <= DUTY_BOUND) && (rsp_data.duty_right <= DUTY_BOUND);
   assign rsp_wait = rsp_valid && rsp_stall;

   // one item at a time
   `TSSC_ASSERT_NXT(a_stall_after_transfer, req_valid && !req_stall, req_stall, "accepted twice")

   // duties stay inside the stepping range
   `TSSC_ASSERT_IMP(a_duty_range, rsp_valid, duty_ok, "duty out of range")

   // no result straight out of reset
   `TSSC_ASSERT_ALL(a_reset_empty, reset, !rsp_valid, "result valid after reset")

   // stalled result holds
   `TSSC_ASSERT_NXT(a_rsp_hold, rsp_wait, rsp_valid && $stable(rsp_data), "stalled result changed")

   // a result only appears after an item was in work
   `TSSC_ASSERT_IMP(a_rsp_source, $rose(rsp_valid), $past(req_stall), "result with no item in work")

endmodule

bind tachometer_speed_step_controller tssc_chk u_chk (.*);
